// File: design/arxbd_pkg.sv
// Shared types, constants and microcode for the ARX block decrypt core.
// No dependencies; imported by arxbd_round and arx_block_decrypt_cbc_top.
package arxbd_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;

    // Alzette round constants, indexed by step mod 5
    localparam t_word RCON [0:4] = '{
        32'hB7E1_5162, 32'hBF71_5880, 32'h38B4_DA56, 32'h324E_7738, 32'hBB11_85EB
    };

    // configuration register indexes
    localparam logic [7:0] REG_KEY0 = 8'd0;
    localparam logic [7:0] REG_KEY1 = 8'd1;
    localparam logic [7:0] REG_KEY2 = 8'd2;
    localparam logic [7:0] REG_KEY3 = 8'd3;

    typedef logic [1:0] t_pc;

    localparam t_pc PC_LOAD   = 2'd0;
    localparam t_pc PC_ROUND  = 2'd1;
    localparam t_pc PC_FINISH = 2'd2;
    localparam t_pc PC_SPARE  = 2'd3;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_EMPTY,
        COND_STEP_MORE,
        COND_OUT_BUSY
    } t_cond;

    // wait_c true: hold the step, no action. Else act, then jump if jump_c.
    typedef struct packed {
        t_cond wait_c;
        t_cond jump_c;
        t_pc   target;
        logic  do_load;
        logic  do_round;
        logic  do_finish;
    } t_ctrl;

    localparam t_ctrl UCODE [0:3] = '{
        '{wait_c: COND_IN_EMPTY, jump_c: COND_NEVER,     target: PC_LOAD,
          do_load: 1'b1, do_round: 1'b0, do_finish: 1'b0},
        '{wait_c: COND_NEVER,    jump_c: COND_STEP_MORE, target: PC_ROUND,
          do_load: 1'b0, do_round: 1'b1, do_finish: 1'b0},
        '{wait_c: COND_OUT_BUSY, jump_c: COND_ALWAYS,    target: PC_LOAD,
          do_load: 1'b0, do_round: 1'b0, do_finish: 1'b1},
        '{wait_c: COND_NEVER,    jump_c: COND_ALWAYS,    target: PC_LOAD,
          do_load: 1'b0, do_round: 1'b0, do_finish: 1'b0}
    };

    function automatic t_word rotr32(input t_word v, input int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

// File: design/arxbd_round.sv
// One decryption round: inverse Alzette box, then key and step whitening.
// Depends on arxbd_pkg.
module arxbd_round (
    input  arxbd_pkg::t_word i_x,
    input  arxbd_pkg::t_word i_y,
    input  arxbd_pkg::t_word i_rcon,
    input  arxbd_pkg::t_word i_key_x,
    input  arxbd_pkg::t_word i_key_y,
    input  arxbd_pkg::t_word i_step,
    output arxbd_pkg::t_word o_x,
    output arxbd_pkg::t_word o_y
);
    import arxbd_pkg::*;

    always_comb begin
        t_word x;
        t_word y;
        x = i_x;
        y = i_y;
        x = x ^ i_rcon; y = y ^ rotr32(x, 16); x = x - rotr32(y, 24);
        x = x ^ i_rcon; y = y ^ rotr32(x, 31); x = x - y;
        x = x ^ i_rcon; y = y ^ rotr32(x, 17); x = x - rotr32(y, 17);
        x = x ^ i_rcon; y = y ^ rotr32(x, 24); x = x - rotr32(y, 31);
        o_x = x ^ i_key_x ^ i_step;
        o_y = y ^ i_key_y;
    end

endmodule

// File: design/arx_block_decrypt_cbc_top.sv
// ARX block decrypt core in CBC mode, microcoded round sequencer.
// Depends on arxbd_pkg and arxbd_round.
//
// Usage:
//   s_axis: one ciphertext block per word, tuser flags a new chain.
//   m_axis: one plaintext block per word.
//   cfg:    key writes by index, always ready; write only while idle.
// A small microcode program steps load, ROUNDS round steps through one
// shared round unit (one per cycle), then the CBC finish into the output
// register. The next input is taken only once the previous block has
// passed its finish step, as the round unit serves one block at a time.
// While a result waits in the output register the core still loads and
// runs the next block; the finish step holds until the output is taken,
// and s_axis_tready stays low meanwhile.
// Reset clears keys, chaining value, sequencer and output valid; no
// clearing pass is needed.
module arx_block_decrypt_cbc_top #(
    parameter int unsigned ROUNDS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,   // [31:0] cipher_x, [63:32] cipher_y
    input  logic                s_axis_tuser,   // [0] first_block
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata,   // [31:0] plain_x, [63:32] plain_y
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  arxbd_pkg::t_word    i_cfg_data
);
    import arxbd_pkg::*;

    localparam int unsigned STEP_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(ROUNDS - 1);
    localparam logic [2:0] M5_INIT = 3'((ROUNDS - 1) % 5);

    t_word r_key0, r_key1, r_key2;
    t_word r_chain_x, r_chain_y;
    t_word r_x, n_x, r_y, n_y;
    t_word r_cx, r_cy;
    logic  r_first;
    logic [STEP_W-1:0] r_step;
    logic [2:0] r_m5;
    t_pc   r_pc, n_pc;
    logic  r_ovalid;
    t_word r_px, r_py;

    t_ctrl ctrl;
    logic  wait_hit, jump_hit;
    t_word rnd_x, rnd_y, key_x, key_y;

    assign ctrl = UCODE[r_pc];

    function automatic logic cond_eval(input t_cond c, input logic in_empty,
                                       input logic step_more, input logic out_busy);
        logic res;
        unique case (c)
            COND_NEVER:     res = 1'b0;
            COND_ALWAYS:    res = 1'b1;
            COND_IN_EMPTY:  res = in_empty;
            COND_STEP_MORE: res = step_more;
            COND_OUT_BUSY:  res = out_busy;
            default:        res = 1'b0;
        endcase
        return res;
    endfunction

    always_comb begin
        wait_hit = cond_eval(ctrl.wait_c, !s_axis_tvalid, r_step != '0,
                             r_ovalid && !m_axis_tready);
        jump_hit = cond_eval(ctrl.jump_c, !s_axis_tvalid, r_step != '0,
                             r_ovalid && !m_axis_tready);
        priority if (wait_hit) begin
            n_pc = r_pc;
        end else if (jump_hit) begin
            n_pc = ctrl.target;
        end else begin
            n_pc = r_pc + 2'd1;
        end
    end

    assign s_axis_tready = ctrl.do_load;
    assign o_cfg_ready   = 1'b1;

    assign key_x = r_step[0] ? r_key1 : r_key0;
    assign key_y = r_step[0] ? r_key2 : r_key1;

    arxbd_round u_round (
        .i_x     (r_x),
        .i_y     (r_y),
        .i_rcon  (RCON[r_m5]),
        .i_key_x (key_x),
        .i_key_y (key_y),
        .i_step  ({{(WORD_W - STEP_W){1'b0}}, r_step}),
        .o_x     (rnd_x),
        .o_y     (rnd_y)
    );

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (ctrl.do_load) begin
            n_x = s_axis_tdata[31:0] ^ r_key0;
            n_y = s_axis_tdata[63:32] ^ r_key1;
        end else if (ctrl.do_round) begin
            n_x = rnd_x;
            n_y = rnd_y;
        end
    end

    // control and key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_LOAD;
            r_ovalid  <= 1'b0;
            r_key0    <= '0;
            r_key1    <= '0;
            r_key2    <= '0;
            r_chain_x <= '0;
            r_chain_y <= '0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KEY0: r_key0 <= i_cfg_data;
                    REG_KEY1: r_key1 <= i_cfg_data;
                    REG_KEY2: r_key2 <= i_cfg_data;
                    REG_KEY3: ;  // not used by the key schedule
                    default:  ;
                endcase
            end
            if (ctrl.do_finish && !wait_hit) begin
                r_ovalid  <= 1'b1;
                r_chain_x <= r_cx;
                r_chain_y <= r_cy;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        if (ctrl.do_load && !wait_hit) begin
            r_cx    <= s_axis_tdata[31:0];
            r_cy    <= s_axis_tdata[63:32];
            r_first <= s_axis_tuser;
            r_step  <= STEP_INIT;
            r_m5    <= M5_INIT;
        end else if (ctrl.do_round) begin
            r_step <= r_step - 1'b1;
            r_m5   <= (r_m5 == 3'd0) ? 3'd4 : r_m5 - 3'd1;
        end
        if (ctrl.do_finish && !wait_hit) begin
            r_px <= r_x ^ (r_first ? '0 : r_chain_x);
            r_py <= r_y ^ (r_first ? '0 : r_chain_y);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_py, r_px};

    a_load_to_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_pc == PC_ROUND)
        else $error("accepted block did not start its rounds");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc == PC_ROUND && r_step == '0 |=> r_pc == PC_FINISH)
        else $error("round count did not end in the finish step");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_pc) == PC_FINISH)
        else $error("output raised outside the finish step");

    a_no_spare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc != PC_SPARE)
        else $error("sequencer reached the spare step");

endmodule

// File: sim/arxbd_checker.sv
`timescale 1ns / 100ps
// Checker for the ARX CBC block decrypt core: follows key writes and ciphertext words,
// predicts each plaintext word in order and compares it with the output stream.
// Depends on arxbd_pkg for the word type and key register indexes.
module arxbd_checker #(
    parameter int unsigned ROUNDS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [63:0]         i_in_data,
    input  logic                i_in_first,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [63:0]         i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  arxbd_pkg::t_word    i_cfg_data,
    output int                  o_pending,
    output int                  o_errors
);
    import arxbd_pkg::*;

    typedef struct packed {
        t_word py;
        t_word px;
    } t_plain_word;

    localparam t_word ALZ_CONST [0:4] = '{
        32'hB7E1_5162, 32'hBF71_5880, 32'h38B4_DA56, 32'h324E_7738, 32'hBB11_85EB
    };

    t_word       key_w [0:3];
    t_word       chain_x;
    t_word       chain_y;
    t_plain_word plain_expected [$];
    int          mismatches;

    function automatic t_word ror(input t_word v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // undo whitening and the round sequence, CBC chaining applied by caller
    function automatic t_plain_word undo_rounds(input t_word cx, input t_word cy);
        t_word       x;
        t_word       y;
        t_word       c;
        int          step;
        t_plain_word r;
        x = cx ^ key_w[0];
        y = cy ^ key_w[1];
        for (step = ROUNDS - 1; step >= 0; step--) begin
            c = ALZ_CONST[step % 5];
            x = x ^ c; y = y ^ ror(x, 16); x = x - ror(y, 24);
            x = x ^ c; y = y ^ ror(x, 31); x = x - y;
            x = x ^ c; y = y ^ ror(x, 17); x = x - ror(y, 17);
            x = x ^ c; y = y ^ ror(x, 24); x = x - ror(y, 31);
            x = x ^ key_w[step & 1];
            y = y ^ key_w[1 + (step & 1)];
            x = x ^ t_word'(step);
        end
        r.px = x;
        r.py = y;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_plain_word p;
        t_plain_word want;
        if (!i_rst_n) begin
            key_w   = '{default: '0};
            chain_x = '0;
            chain_y = '0;
            plain_expected.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY0: key_w[0] = i_cfg_data;
                    REG_KEY1: key_w[1] = i_cfg_data;
                    REG_KEY2: key_w[2] = i_cfg_data;
                    REG_KEY3: key_w[3] = i_cfg_data;
                    default: ;
                endcase
            end
            // output side first: a word leaving now belongs to an older block
            if (i_out_valid && i_out_ready) begin
                if (plain_expected.size() == 0) begin
                    $error("plaintext word %016h with nothing expected", i_out_data);
                    mismatches++;
                end else begin
                    want = plain_expected.pop_front();
                    if (i_out_data[31:0] !== want.px) begin
                        $error("plain_x: expected %08h, got %08h", want.px, i_out_data[31:0]);
                        mismatches++;
                    end
                    if (i_out_data[63:32] !== want.py) begin
                        $error("plain_y: expected %08h, got %08h", want.py, i_out_data[63:32]);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                p = undo_rounds(i_in_data[31:0], i_in_data[63:32]);
                if (i_in_first) begin
                    chain_x = '0;
                    chain_y = '0;
                end
                p.px = p.px ^ chain_x;
                p.py = p.py ^ chain_y;
                chain_x = i_in_data[31:0];
                chain_y = i_in_data[63:32];
                plain_expected.push_back(p);
            end
        end
        o_pending <= plain_expected.size();
        o_errors  <= mismatches;
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for arx_block_decrypt_cbc_top: clock, reset, key writes, ciphertext
// stream and output back-pressure. Depends on arxbd_pkg, the core and arxbd_checker.
module tb;
    import arxbd_pkg::*;

    localparam int unsigned ROUNDS      = 10;
    localparam logic [7:0]  REG_STRAY_LO = REG_KEY3 + 8'd1;
    localparam logic [7:0]  REG_STRAY_HI = 8'hFF;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index   = '0;
    t_word       i_cfg_data    = '0;

    int pending;
    int errors;
    bit idle_on    = 1'b0;
    int stall_left = 0;
    int blocks_sent = 0;
    int restarts    = 0;
    int key_sets    = 1;

    always #5 i_clk = ~i_clk;

    arx_block_decrypt_cbc_top #(.ROUNDS(ROUNDS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    arxbd_checker #(.ROUNDS(ROUNDS)) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_first  (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // output back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_block(input t_word cx, input t_word cy, input logic first);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cy, cx};
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        blocks_sent++;
        if (first) restarts++;
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_block(rand_word(), rand_word(), $urandom_range(0, 7) == 0);
    endtask

    // stop the input stream and wait until every plaintext word is out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_keys(input t_word k0, input t_word k1, input t_word k2,
                             input t_word k3, input logic [7:0] stray);
        logic [7:0] idx [0:4];
        t_word      val [0:4];
        idx = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, stray};
        val = '{k0, k1, k2, k3, $urandom()};
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        key_sets++;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;
        @(posedge i_clk);

        // reset keys; first block relies on the reset chaining value
        send_block(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_block(32'h8000_0000, 32'h0000_0001, 1'b0);
        send_block(32'h0000_0001, 32'h8000_0000, 1'b0);
        send_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_block(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        send_block(32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
        send_block($urandom(), $urandom(), 1'b1);
        send_block($urandom(), $urandom(), 1'b1);
        send_block($urandom(), $urandom(), 1'b0);
        drain();

        load_keys('1, '1, '1, '1, REG_STRAY_LO);
        send_block(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_block(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_block($urandom(), $urandom(), 1'b0);
        send_random(150);
        drain();

        for (int ph = 2; ph < 7; ph++) begin
            if (ph == 4)
                load_keys(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          REG_STRAY_HI);
            else
                load_keys($urandom(), $urandom(), $urandom(), $urandom(),
                          (ph % 2) ? REG_STRAY_LO : REG_STRAY_HI);
            idle_on <= (ph != 3);
            send_random(280);
            drain();
        end

        load_keys('0, '0, '0, '0, REG_STRAY_HI);
        idle_on <= 1'b1;
        send_random(80);
        idle_on <= 1'b0;
        send_random(200);
        drain();
        repeat (ROUNDS + 4) @(posedge i_clk);

        $display("Decrypted %0d ciphertext blocks, %0d of them chain restarts,", blocks_sent,
                 restarts);
        $display("under %0d key settings with stray register writes and random stalls.",
                 key_sets);
        if (errors == 0 && pending == 0)
            $display("** arx_block_decrypt_cbc_top: PASSED **");
        else
            $display("** arx_block_decrypt_cbc_top: FAILED **");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d plaintext words outstanding", pending);
        $display("** arx_block_decrypt_cbc_top: FAILED **");
        $finish;
    end

endmodule
